/* sv/tmtw_pkg.sv */
// ----------------------------------------------------------------------------
// Text-mode terminal writer package
// Screen geometry, derived widths, operation codes, word types and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tmtw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int BOTTOM  = (ROWS - 1) * COLUMNS;

    // Derived widths.
    localparam int POS_W  = $clog2(CELLS + 1);
    localparam int RAM_AW = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int CELL_W = 16;

    // Operation codes.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_PLACE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Character and color codes.
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [3:0] FG_BLANK     = 4'd0;
    localparam logic [3:0] FG_GREEN     = 4'd2;
    localparam logic [3:0] FG_RED       = 4'd4;
    localparam logic [3:0] BG_RESET     = 4'd0;

    // Configuration port.
    localparam int         PADDR_W        = 3;
    localparam logic       REG_BACKGROUND = 1'b0;

    // Input word.
    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  character;
        logic [3:0]  fg_color;
        logic        end_of_write;
        logic [5:0]  row;
        logic [6:0]  column;
        logic [10:0] cell_index;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [10:0] cursor_position;
        logic [15:0] cell_value;
        logic        scrolled;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic cnt_clr;
        logic cnt_inc;
        logic mv_rd;
        logic fill;
        logic fill_init;
        logic place;
        logic put;
        logic cursor;
        logic set_scroll;
        logic load_result;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       at_end;
        logic       cnt_mv_end;
        logic       cnt_end;
        logic       put_cursor;
    } t_dp_status;

    // Builds one screen cell from its character and colors.
    function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] ch,
                                                    input logic [3:0] fg,
                                                    input logic [3:0] bg);
        make_cell = {bg, fg, ch};
    endfunction

endpackage

/* sv/text_mode_terminal_writer.sv */
// ----------------------------------------------------------------------------
// Text-mode terminal writer
// Keeps a screen of character cells and a write position, and serves put,
// place, clear and read commands.
// ----------------------------------------------------------------------------
// Usage: drive a word on i_in and raise start; it is taken at the clock edge
// where start is high and busy is low. The result word appears on o_out for
// exactly one cycle with o_done high; the receiver cannot stall it. A new
// word can be taken in the cycle the previous result is shown.
// Steps after accept: a place writes its cell when the row and column lie on
// the screen; a read presents the address, then shows the registered read
// data; a put writes the character, then the cursor cell when one is written;
// a put at the screen end first runs a scroll (one memory read and write per
// cell, then the bottom row blank); a clear blanks every cell.
// Every sweep goes through the single write port of the screen memory.
// After reset the block runs a clearing pass over ROWS*COLUMNS cells
// (2000 at 80 by 25) with busy high; the background register can be
// written over the APB port at any time and reads back its value.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  tmtw_pkg::t_in_word           i_in,
    output logic                         o_done,
    output tmtw_pkg::t_out_word          o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tmtw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import tmtw_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status sts;
    logic [3:0] bg;

    // Configuration registers.
    tmtw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_bg    (bg)
    );

    // Controller.
    tmtw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // Datapath with the screen memory.
    tmtw_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_bg    (bg),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out)
    );

endmodule

/* sv/tmtw_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/tmtw_regs.sv */
// ----------------------------------------------------------------------------
// Terminal writer configuration registers
// APB-style register port holding the background color.
// ----------------------------------------------------------------------------
module tmtw_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmtw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [3:0]                  o_bg
);
    import tmtw_pkg::*;

    logic [3:0] r_bg;
    logic       wr_bg;

    // The register is written in the access cycle of a write.
    assign pready = 1'b1;
    assign wr_bg  = psel && penable && pwrite && pready && (paddr[2] == REG_BACKGROUND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg <= BG_RESET;
        end else if (wr_bg) begin
            r_bg <= pwdata[3:0];
        end
    end

    // Read data for the addressed register; unmapped addresses read zero.
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_BACKGROUND) begin
            prdata = {28'd0, r_bg};
        end
    end

    assign o_bg = r_bg;

endmodule

/* sv/tmtw_ctrl.sv */
// ----------------------------------------------------------------------------
// Terminal writer controller
// Sequences the screen clearing pass, the scroll move and blank, and the
// put, place, clear and read operations over the shared screen memory.
// ----------------------------------------------------------------------------
module tmtw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    output logic                 o_done,
    output tmtw_pkg::t_ctrl_cmd  o_cmd,
    input  tmtw_pkg::t_dp_status i_sts
);
    import tmtw_pkg::*;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_SCROLL = 4'd3;
    localparam logic [3:0] S_MVTAIL = 4'd4;
    localparam logic [3:0] S_BLANK  = 4'd5;
    localparam logic [3:0] S_PUT    = 4'd6;
    localparam logic [3:0] S_CURSOR = 4'd7;
    localparam logic [3:0] S_CLEAR  = 4'd8;
    localparam logic [3:0] S_RDWAIT = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_ctrl_cmd  cmd;

    // A new word is taken while idle or while the last result is shown.
    assign o_busy = !((r_state == S_IDLE) || (r_state == S_DONE));
    assign o_done = (r_state == S_DONE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_INIT: begin
                cmd.fill      = 1'b1;
                cmd.fill_init = 1'b1;
                cmd.cnt_inc   = 1'b1;
                if (i_sts.cnt_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE, S_DONE: begin
                if (i_start) begin
                    cmd.capture = 1'b1;
                    n_state     = S_EXEC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_PUT: begin
                        if (i_sts.at_end) begin
                            cmd.set_scroll = 1'b1;
                            cmd.cnt_clr    = 1'b1;
                            n_state        = S_SCROLL;
                        end else begin
                            n_state = S_PUT;
                        end
                    end
                    OP_PLACE: begin
                        cmd.place       = 1'b1;
                        cmd.load_result = 1'b1;
                        n_state         = S_DONE;
                    end
                    OP_CLEAR: begin
                        cmd.cnt_clr = 1'b1;
                        n_state     = S_CLEAR;
                    end
                    OP_READ: begin
                        // The read address is presented in this cycle.
                        n_state = S_RDWAIT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCROLL: begin
                cmd.mv_rd   = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_mv_end) begin
                    n_state = S_MVTAIL;
                end
            end
            S_MVTAIL: begin
                // The last moved cell is written in this cycle.
                n_state = S_BLANK;
            end
            S_BLANK: begin
                cmd.fill    = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_end) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                cmd.put = 1'b1;
                if (i_sts.put_cursor) begin
                    n_state = S_CURSOR;
                end else begin
                    cmd.load_result = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_CURSOR: begin
                cmd.cursor      = 1'b1;
                cmd.load_result = 1'b1;
                n_state         = S_DONE;
            end
            S_CLEAR: begin
                cmd.fill    = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_end) begin
                    cmd.load_result = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_RDWAIT: begin
                cmd.load_result = 1'b1;
                n_state         = S_DONE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // A result is shown for a single cycle.
    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // An accepted word always starts execution.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_EXEC))
        else $error("accepted word did not start execution");

    // A scroll always runs its blank pass before the put step.
    a_tail_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MVTAIL) |=> (r_state == S_BLANK))
        else $error("scroll move not followed by bottom row blank");
`endif

endmodule

/* sv/tmtw_dp.sv */
// ----------------------------------------------------------------------------
// Terminal writer datapath
// Holds the write position, the captured word, the sweep counter and the
// result word, and drives the screen memory ports.
// ----------------------------------------------------------------------------
module tmtw_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tmtw_pkg::t_in_word   i_in,
    input  logic [3:0]           i_bg,
    input  tmtw_pkg::t_ctrl_cmd  i_cmd,
    output tmtw_pkg::t_dp_status o_sts,
    output tmtw_pkg::t_out_word  o_out
);
    import tmtw_pkg::*;

    t_in_word                r_in;
    t_out_word               r_out;
    logic [POS_W-1:0]        r_pos;
    logic [POS_W-1:0]        n_pos;
    logic [COL_W-1:0]        r_col;
    logic [COL_W-1:0]        n_col;
    logic [RAM_AW-1:0]       r_cnt;
    logic                    r_mv_valid;
    logic [RAM_AW-1:0]       r_mv_addr;
    logic                    r_scrolled;

    logic                    at_end;
    logic                    is_nl;
    logic                    place_ok;
    logic                    idx_ok;
    logic [RAM_AW-1:0]       place_addr;
    logic [POS_W-1:0]        base_pos;
    logic [COL_W-1:0]        base_col;
    logic [POS_W-1:0]        p_pos;
    logic [COL_W-1:0]        p_col;

    logic                    ram_we;
    logic [RAM_AW-1:0]       ram_waddr;
    logic [CELL_W-1:0]       ram_wdata;
    logic [RAM_AW-1:0]       ram_raddr;
    logic [CELL_W-1:0]       ram_rdata;

    // Decoded conditions on the captured word and the position.
    assign at_end   = (r_pos == POS_W'(CELLS));
    assign is_nl    = (r_in.character == CHAR_NEWLINE);
    assign place_ok = (32'(r_in.row) < ROWS) && (32'(r_in.column) < COLUMNS);
    assign idx_ok   = (32'(r_in.cell_index) < CELLS);
    assign place_addr = RAM_AW'(r_in.row) * RAM_AW'(COLUMNS) + RAM_AW'(r_in.column);

    // Position after a put; a character other than a newline at the screen
    // end lands on the bottom row after the scroll.
    always_comb begin
        base_pos = at_end ? POS_W'(BOTTOM) : r_pos;
        base_col = at_end ? '0 : r_col;
        if (is_nl) begin
            if (at_end) begin
                p_pos = r_pos;
                p_col = r_col;
            end else begin
                p_pos = r_pos - POS_W'(r_col) + POS_W'(COLUMNS);
                p_col = '0;
            end
        end else begin
            p_pos = base_pos + POS_W'(1);
            p_col = (base_col == COL_W'(COLUMNS - 1)) ? '0 : base_col + COL_W'(1);
        end
    end

    assign n_pos = i_cmd.put ? p_pos : r_pos;
    assign n_col = i_cmd.put ? p_col : r_col;

    // Write position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_col <= '0;
        end else begin
            r_pos <= n_pos;
            r_col <= n_col;
        end
    end

    // Sweep counter for the clearing pass, scroll and clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + RAM_AW'(1);
        end
    end

    // Pending scroll write: the cell read one row down is written in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv_valid <= 1'b0;
        end else begin
            r_mv_valid <= i_cmd.mv_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mv_addr <= r_cnt;
    end

    // Captured word and scroll flag.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scrolled <= 1'b0;
        end else if (i_cmd.capture) begin
            r_scrolled <= 1'b0;
        end else if (i_cmd.set_scroll) begin
            r_scrolled <= 1'b1;
        end
    end

    // Memory write port selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (r_mv_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_mv_addr;
            ram_wdata = ram_rdata;
        end else if (i_cmd.fill) begin
            ram_we    = 1'b1;
            ram_waddr = r_cnt;
            ram_wdata = i_cmd.fill_init ? make_cell(CHAR_SPACE, FG_BLANK, BG_RESET)
                                        : make_cell(CHAR_SPACE, FG_BLANK, i_bg);
        end else if (i_cmd.place && place_ok) begin
            ram_we    = 1'b1;
            ram_waddr = place_addr;
            ram_wdata = make_cell(r_in.character, FG_RED, i_bg);
        end else if (i_cmd.put && !is_nl) begin
            ram_we    = 1'b1;
            ram_waddr = RAM_AW'(base_pos);
            ram_wdata = make_cell(r_in.character, r_in.fg_color, i_bg);
        end else if (i_cmd.cursor) begin
            ram_we    = 1'b1;
            ram_waddr = RAM_AW'(r_pos);
            ram_wdata = make_cell(CHAR_SPACE, FG_GREEN, i_bg);
        end
    end

    // Memory read address: one row below the counter while scrolling.
    assign ram_raddr = i_cmd.mv_rd ? (r_cnt + RAM_AW'(COLUMNS)) : RAM_AW'(r_in.cell_index);

    tmtw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_out.cursor_position <= 11'(n_pos);
            r_out.cell_value      <= ((r_in.operation == OP_READ) && idx_ok) ? ram_rdata
                                                                             : '0;
            r_out.scrolled        <= r_scrolled;
        end
    end

    assign o_out = r_out;

    // Status to the controller.
    assign o_sts.op         = r_in.operation;
    assign o_sts.at_end     = at_end;
    assign o_sts.cnt_mv_end = (r_cnt == RAM_AW'(BOTTOM - 1));
    assign o_sts.cnt_end    = (r_cnt == RAM_AW'(CELLS - 1));
    assign o_sts.put_cursor = r_in.end_of_write && (p_pos != POS_W'(CELLS));

`ifndef SYNTHESIS
    // The write position never passes the screen end.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(CELLS))
        else $error("write position beyond screen end");

    // At the screen end the column count sits at the start of a row.
    a_end_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == POS_W'(CELLS)) |-> (r_col == '0))
        else $error("column count out of step with write position");

    // Every memory write lands inside the screen.
    a_write_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (32'(ram_waddr) < CELLS))
        else $error("screen memory write outside the screen");
`endif

endmodule
